FILE: design/lapt_pkg.sv
// Shared types and constants for the LRU age preload tracker.
package lapt_pkg;

    localparam int AGE_W = 5;

    localparam logic ACT_UNLOAD = 1'b0;
    localparam logic ACT_LOAD   = 1'b1;

    typedef struct packed {
        logic [15:0] item_key;
        logic        eligible;
    } t_in_item;

    typedef struct packed {
        logic        action;
        logic [15:0] target_key;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic      vld;
        t_out_item item;
    } t_res_push;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE,
        S_UNLOAD,
        S_LOAD
    } t_state;

endpackage

FILE: design/lapt_ram.sv
// Generic simple dual-port RAM with registered read.
module lapt_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/lapt_obuf.sv
// Output register for result beats.
module lapt_obuf
    import lapt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_push i_push,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_data;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_push.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (o_free && i_push.vld) begin
            r_data <= i_push.item;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/lapt_core.sv
// Sequencer: search pass, age update pass, eviction and insert over the slot RAM.
module lapt_core
    import lapt_pkg::*;
#(
    parameter int SLOTS    = 20,
    parameter int KEY_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    input  logic      i_out_free,
    output t_res_push o_push
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ENT_W = KEY_BITS + AGE_W;

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic                 r_dv;
    logic [IDX_W-1:0]     r_d_idx;
    logic [SLOTS-1:0]     r_valid;
    logic [SLOTS-1:0]     n_valid;
    logic [KEY_BITS-1:0]  r_key;
    logic [KEY_BITS-1:0]  n_key;
    logic                 r_hit;
    logic                 n_hit;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [IDX_W-1:0]     n_hit_idx;
    logic [AGE_W-1:0]     r_hit_age;
    logic [AGE_W-1:0]     n_hit_age;
    logic                 r_free;
    logic                 n_free;
    logic [IDX_W-1:0]     r_free_idx;
    logic [IDX_W-1:0]     n_free_idx;
    logic                 r_evict;
    logic                 n_evict;
    logic [IDX_W-1:0]     r_evict_idx;
    logic [IDX_W-1:0]     n_evict_idx;
    logic [KEY_BITS-1:0]  r_evict_key;
    logic [KEY_BITS-1:0]  n_evict_key;

    logic                 rd_en;
    logic                 pass_done;
    logic                 start;
    logic [ENT_W-1:0]     rdata;
    logic [KEY_BITS-1:0]  rd_key;
    logic [AGE_W-1:0]     rd_age;
    logic [AGE_W-1:0]     age_inc;
    logic                 rd_vld;
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [ENT_W-1:0]     wdata;
    logic [IDX_W-1:0]     ins_idx;

    assign rd_en     = (r_state == S_SEARCH || r_state == S_UPDATE)
                       && (r_cnt != CNT_W'(SLOTS));
    assign pass_done = (r_cnt == CNT_W'(SLOTS)) && !r_dv;
    assign start     = (r_state == S_IDLE) && i_in_valid && i_in_data.eligible;
    assign rd_key    = rdata[AGE_W +: KEY_BITS];
    assign rd_age    = rdata[AGE_W-1:0];
    assign age_inc   = rd_age + AGE_W'(1);
    assign rd_vld    = r_dv && r_valid[r_d_idx];

    // Lowest free slot after eviction; the evicted slot may lie below the one found earlier.
    always_comb begin
        if (r_evict && (!r_free || r_evict_idx < r_free_idx)) begin
            ins_idx = r_evict_idx;
        end else if (r_free) begin
            ins_idx = r_free_idx;
        end else begin
            ins_idx = '0;
        end
    end

    lapt_ram #(
        .WIDTH(ENT_W),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (rd_en),
        .i_raddr(r_cnt[IDX_W-1:0]),
        .o_rdata(rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (pass_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (pass_done) begin
                    if (r_hit) begin
                        n_state = S_IDLE;
                    end else if (r_evict) begin
                        n_state = S_UNLOAD;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_UNLOAD: begin
                if (i_out_free) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: result beats and RAM writes
    always_comb begin
        o_in_stall             = (r_state != S_IDLE);
        o_push.vld             = 1'b0;
        o_push.item.action     = ACT_LOAD;
        o_push.item.target_key = 16'(r_key);
        o_push.item.last       = 1'b1;
        we                     = 1'b0;
        waddr                  = r_d_idx;
        wdata                  = {rd_key, rd_age};
        case (r_state)
            S_UPDATE: begin
                if (rd_vld) begin
                    if (r_hit) begin
                        if (r_d_idx == r_hit_idx) begin
                            we    = 1'b1;
                            wdata = {rd_key, AGE_W'(0)};
                        end else if (rd_age < r_hit_age) begin
                            we    = 1'b1;
                            wdata = {rd_key, age_inc};
                        end
                    end else begin
                        we = 1'b1;
                        if (age_inc >= AGE_W'(SLOTS) && !r_evict) begin
                            wdata = {rd_key, AGE_W'(0)};
                        end else begin
                            wdata = {rd_key, age_inc};
                        end
                    end
                end
            end
            S_UNLOAD: begin
                o_push.vld             = i_out_free;
                o_push.item.action     = ACT_UNLOAD;
                o_push.item.target_key = 16'(r_evict_key);
                o_push.item.last       = 1'b0;
            end
            S_LOAD: begin
                o_push.vld = i_out_free;
                we         = i_out_free;
                waddr      = ins_idx;
                wdata      = {r_key, AGE_W'(0)};
            end
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_cnt       = r_cnt;
        n_valid     = r_valid;
        n_key       = r_key;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_age   = r_hit_age;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_evict     = r_evict;
        n_evict_idx = r_evict_idx;
        n_evict_key = r_evict_key;
        if (rd_en) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (pass_done) begin
            n_cnt = '0;
        end
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_key   = KEY_BITS'(i_in_data.item_key);
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_evict = 1'b0;
                    n_cnt   = '0;
                end
            end
            S_SEARCH: begin
                if (rd_vld && rd_key == r_key && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_d_idx;
                    n_hit_age = rd_age;
                end
                if (r_dv && !r_valid[r_d_idx] && !r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_d_idx;
                end
            end
            S_UPDATE: begin
                // Drop the first entry that ages out on a miss.
                if (rd_vld && !r_hit && age_inc >= AGE_W'(SLOTS) && !r_evict) begin
                    n_evict            = 1'b1;
                    n_evict_idx        = r_d_idx;
                    n_evict_key        = rd_key;
                    n_valid[r_d_idx]   = 1'b0;
                end
            end
            S_LOAD: begin
                if (i_out_free) begin
                    n_valid[ins_idx] = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_dv    <= 1'b0;
            r_valid <= '0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            r_evict <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dv    <= rd_en;
            r_valid <= n_valid;
            r_hit   <= n_hit;
            r_free  <= n_free;
            r_evict <= n_evict;
        end
        r_d_idx     <= r_cnt[IDX_W-1:0];
        r_key       <= n_key;
        r_hit_idx   <= n_hit_idx;
        r_hit_age   <= n_hit_age;
        r_free_idx  <= n_free_idx;
        r_evict_idx <= n_evict_idx;
        r_evict_key <= n_evict_key;
    end

endmodule

FILE: design/lru_age_preload_tracker.sv
// Top level of the LRU age preload tracker.
//
// Input channel: i_in_valid / o_in_stall carry one request beat (item_key,
// eligible). A beat with eligible low is taken and dropped at once. An
// eligible beat runs a search pass and an age update pass over the slot
// RAM, one slot per cycle; the RAM read is registered, and each pass
// closes after the last read data is handled. A hit holds the input
// stalled through both passes; a miss also stalls it for the load beat,
// for an unload beat if one is needed, and for any wait for the output
// register. The next request is taken once the block is idle again.
// Output channel: o_out_valid / i_out_stall carry result beats: on a miss
// an optional unload of the evicted key (last low), then a load of the
// requested key (last high). A hit gives no beat.
// While the receiver stalls, the output register holds its beat; the
// sequencer waits to emit further beats but the next request is taken
// once the final beat has entered the register.
// Reset empties every slot (valid bits cleared); no clearing pass is run.
module lru_age_preload_tracker
    import lapt_pkg::*;
#(
    parameter int SLOTS    = 20,
    parameter int KEY_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_res_push push;
    logic      out_free;

    lapt_core #(
        .SLOTS   (SLOTS),
        .KEY_BITS(KEY_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_data (i_in_data),
        .o_in_stall(o_in_stall),
        .i_out_free(out_free),
        .o_push    (push)
    );

    lapt_obuf u_obuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_free (out_free),
        .o_valid(o_out_valid),
        .i_stall(i_out_stall),
        .o_data (o_out_data)
    );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the LRU age preload tracker.
`timescale 1ns / 100ps

module testbench;
    import lapt_pkg::*;

    localparam int N_SLOTS      = 20;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD    = 400;
    localparam int POOL_MIN     = 22;
    localparam int POOL_MAX     = 30;

    // Residency predictor plus the queue of result beats it has promised.
    class lru_scoreboard;
        logic [15:0]      key_tab [N_SLOTS];
        logic [AGE_W-1:0] age_tab [N_SLOTS];
        bit               used_tab [N_SLOTS];
        t_out_item        want_q [$];
        int               errors;

        function new();
            for (int i = 0; i < N_SLOTS; i++) begin
                key_tab[i]  = '0;
                age_tab[i]  = '0;
                used_tab[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function void note_request(t_in_item req);
            int        hit_slot;
            int        free_slot;
            bit        evicted;
            t_out_item beat;
            hit_slot  = -1;
            free_slot = -1;
            evicted   = 1'b0;
            if (!req.eligible) return;
            for (int i = 0; i < N_SLOTS; i++) begin
                if (used_tab[i] && key_tab[i] == req.item_key && hit_slot < 0) hit_slot = i;
            end
            if (hit_slot >= 0) begin
                // Hit: only entries younger than the hit one move up.
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (used_tab[i] && age_tab[i] < age_tab[hit_slot]) age_tab[i] = age_tab[i] + 1'b1;
                end
                age_tab[hit_slot] = '0;
                return;
            end
            for (int i = 0; i < N_SLOTS; i++) begin
                if (used_tab[i]) begin
                    age_tab[i] = age_tab[i] + 1'b1;
                    if (age_tab[i] >= N_SLOTS && !evicted) begin
                        used_tab[i]     = 1'b0;
                        age_tab[i]      = '0;
                        beat.action     = ACT_UNLOAD;
                        beat.target_key = key_tab[i];
                        beat.last       = 1'b0;
                        want_q.insert(want_q.size(), beat);
                        evicted = 1'b1;
                    end
                end
            end
            for (int i = 0; i < N_SLOTS; i++) begin
                if (!used_tab[i] && free_slot < 0) free_slot = i;
            end
            if (free_slot < 0) free_slot = 0;
            used_tab[free_slot] = 1'b1;
            key_tab[free_slot]  = req.item_key;
            age_tab[free_slot]  = '0;
            beat.action     = ACT_LOAD;
            beat.target_key = req.item_key;
            beat.last       = 1'b1;
            want_q.insert(want_q.size(), beat);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (want_q.size() == 0) begin
                $display("%0t: unexpected beat: action %0b key %h last %0b",
                         $time, got.action, got.target_key, got.last);
                errors++;
                return;
            end
            want = want_q.pop_front();
            if (got.action !== want.action) begin
                $display("%0t: action mismatch: expected %0b, actual %0b",
                         $time, want.action, got.action);
                errors++;
            end
            if (got.target_key !== want.target_key) begin
                $display("%0t: target_key mismatch: expected %h, actual %h",
                         $time, want.target_key, got.target_key);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch: expected %0b, actual %0b",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    lru_scoreboard req_sb = new();

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          long_hold_go   = 1'b0;
    bit          long_hold_done = 1'b0;
    logic [15:0] key_pool [POOL_MAX];
    int          pool_n = POOL_MIN;

    lru_age_preload_tracker #(
        .SLOTS    (N_SLOTS),
        .KEY_BITS (16)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: check every accepted beat, then pick the next stall.
    initial begin : result_sink
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) req_sb.check_result(out_data);
            if (hold_cnt > 0) begin
                hold_cnt--;
                if (hold_cnt == 0) long_hold_done = 1'b1;
                out_stall <= 1'b1;
            end else if (long_hold_go && !long_hold_done) begin
                hold_cnt = LONG_HOLD;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Offer one request beat; valid stays high into the next call unless it idles.
    task automatic send_beat(input t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        req_sb.note_request(req);
    endtask

    task automatic send_key(input logic [15:0] key, input logic elig);
        t_in_item req;
        req.item_key = key;
        req.eligible = elig;
        send_beat(req);
    endtask

    // Hold off the sender until every promised beat is out and the block is quiet.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (req_sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic t_in_item pick_request();
        t_in_item req;
        int       roll;
        roll = $urandom_range(99);
        req.eligible = (roll >= 10);
        if (roll < 25) req.item_key = 16'($urandom);
        else req.item_key = key_pool[$urandom_range(pool_n - 1)];
        return req;
    endfunction

    task automatic run_random_phase(input int send_pct, input int recv_pct, input int n_items);
        int       sent;
        t_in_item req;
        sent           = 0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        pool_n = $urandom_range(POOL_MIN, POOL_MAX);
        for (int k = 0; k < pool_n; k++) key_pool[k] = 16'($urandom);
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        while (sent < n_items) begin
            req = pick_request();
            send_beat(req);
            sent++;
        end
        wait_drained();
    endtask

    initial begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 35;
        recv_stall_pct = 70;
        send_key(16'hFFFF, 1'b0);      // dropped while empty
        send_key(16'h0000, 1'b1);
        send_key(16'hFFFF, 1'b1);
        send_key(16'h0000, 1'b0);      // dropped although resident
        send_key(16'h0000, 1'b1);      // hit on the older entry
        send_key(16'h0000, 1'b1);      // hit on the youngest entry
        for (int b = 0; b < 16; b++) send_key(16'h0001 << b, 1'b1);
        send_key(16'h5555, 1'b1);
        send_key(16'hAAAA, 1'b1);      // table now full
        send_key(16'h1234, 1'b1);      // miss at capacity, evict the oldest
        send_key(16'h0000, 1'b1);      // hit on the oldest entry
        send_key(16'hFFFF, 1'b1);      // reload the evicted key
        wait_drained();

        run_random_phase(35, 70, 620);
        run_random_phase(70, 35, 620);
        long_hold_go = 1'b1;
        run_random_phase(0, 0, 610);

        if (req_sb.errors == 0 && req_sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
